@@ src/bond_graph_relation_matrix_unit_defines.svh @@
// Assertion macros used by the checker file of this block.
`ifndef BOND_GRAPH_RELATION_MATRIX_UNIT_DEFINES_SVH
`define BOND_GRAPH_RELATION_MATRIX_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BGRM_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BGRM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/bgrm_pkg.sv @@
package bgrm_pkg;

   // Field widths and fixed sizes.
   localparam int ATOM_W        = 6;
   localparam int CNT_W         = 7;
   localparam int MAX_ATOMS     = 64;
   localparam int MAX_BONDS_DEF = 128;
   localparam logic [CNT_W-1:0] ATOM_COUNT_RST = 7'd64;

   // Relation codes.
   localparam logic [1:0] REL_BONDED    = 2'd0;
   localparam logic [1:0] REL_ONE_THREE = 2'd1;
   localparam logic [1:0] REL_ONE_FOUR  = 2'd2;
   localparam logic [1:0] REL_NONE      = 2'd3;

   // Status codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
   localparam logic [1:0] STAT_NOT_BUILT = 2'd2;
   localparam logic [1:0] STAT_LIST_FULL = 2'd3;

   // Which atom pair the cell port addresses.
   typedef enum logic [1:0] {
      TGT_IN,
      TGT_BOND,
      TGT_SHARE,
      TGT_CROSS
   } tgt_sel_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LD_CHK,
      ST_LD_ADJA,
      ST_LD_ADJB,
      ST_LD_LAST,
      ST_BLD_INIT,
      ST_BLD_I,
      ST_BLD_IRD,
      ST_BLD_ROWA,
      ST_BLD_ROWB,
      ST_BLD_BWR,
      ST_BLD_J,
      ST_BLD_JRD,
      ST_BLD_SEL,
      ST_BLD_SHWR,
      ST_BLD_X,
      ST_BLD_XRD,
      ST_QRD,
      ST_RESULT
   } bgrm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        clear_mol;
      logic        store_bond;
      logic        adj_wr_a;
      logic        adj_wr_b;
      logic        build_init;
      logic        rd_bond_i;
      logic        cap_i;
      logic        cap_rowa;
      logic        cap_rowb;
      logic        cap_j;
      logic        i_inc;
      logic        j_init;
      logic        j_inc;
      logic        k_clr;
      logic        k_inc;
      logic        cell_rd;
      logic        cell_wr;
      logic        rel_load;
      logic        stat_load;
      logic        set_ready;
      logic        rsp_load;
      tgt_sel_type tgt;
      logic [1:0]  cell_val;
      logic [1:0]  stat_val;
   } bgrm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic func;
      logic last;
      logic bad_index;
      logic list_full;
      logic ready;
      logic i_done;
      logic j_done;
      logic shared;
      logic linked;
      logic cell_is3;
      logic k_last;
      logic out_busy;
   } bgrm_stat_type;

endpackage

@@ src/bgrm_datapath.sv @@
module bgrm_datapath import bgrm_pkg::*; #(
   parameter int MAX_BONDS = MAX_BONDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   input  logic              req_func,
   input  logic [ATOM_W-1:0] req_atom_a,
   input  logic [ATOM_W-1:0] req_atom_b,
   input  logic              req_last_bond,
   input  bgrm_cmd_type      cmd,
   output bgrm_stat_type     st,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [1:0]        rsp_relation,
   output logic [1:0]        rsp_status
);

   localparam int CW    = $clog2(MAX_BONDS + 1);
   localparam int BIW   = $clog2(MAX_BONDS);
   localparam int ROW_W = 2 * MAX_ATOMS;
   localparam int SH_W  = ATOM_W + 1;

   logic [CNT_W-1:0]     atom_count_ff;
   logic                 func_ff, last_ff;
   logic [ATOM_W-1:0]    a_ff, b_ff;
   logic [CW-1:0]        total_ff, i_ff, j_ff;
   logic                 ready_ff;
   logic [1:0]           k_ff;
   logic [ATOM_W-1:0]    ai_ff, bi_ff, aj_ff, bj_ff;
   logic [MAX_ATOMS-1:0] row_a_ff, row_b_ff;
   logic [1:0]           rel_ff, stat_ff;
   logic                 rsp_valid_ff;
   logic [1:0]           rsp_relation_ff, rsp_status_ff;

   // Adjacency rows.
   logic [MAX_ATOMS-1:0] adj_mem_ff [MAX_ATOMS];
   logic [MAX_ATOMS-1:0] adj_valid_ff;
   logic [MAX_ATOMS-1:0] adj_q_ff;
   logic                 adj_rv_ff;
   logic [ATOM_W-1:0]    adj_raddr, adj_waddr;
   logic [MAX_ATOMS-1:0] adj_row, adj_wdata;
   logic                 adj_we;

   // Bond list.
   logic [2*ATOM_W-1:0]  bond_mem_ff [MAX_BONDS];
   logic [2*ATOM_W-1:0]  bond_q_ff;
   logic [BIW-1:0]       bond_raddr;

   // Relation cells, one row per smaller atom index.
   logic [ROW_W-1:0]     cell_mem_ff [MAX_ATOMS];
   logic [MAX_ATOMS-1:0] cell_valid_ff;
   logic [ROW_W-1:0]     cell_q_ff;
   logic                 cell_rv_ff;
   logic [ATOM_W-1:0]    crow_ff, ccol_ff;
   logic [ATOM_W-1:0]    tgt_x, tgt_y, tgt_row, tgt_col;
   logic [1:0]           pair_sel, share_k;
   logic [ROW_W-1:0]     cell_base, cell_wdata;
   logic [SH_W-1:0]      cell_shift;
   logic [1:0]           cell_val;
   logic [CNT_W-1:0]     n_valid;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         atom_count_ff <= ATOM_COUNT_RST;
      end else if (csr_wr_en) begin
         atom_count_ff <= csr_wr_data;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         a_ff    <= req_atom_a;
         b_ff    <= req_atom_b;
         last_ff <= req_last_bond;
      end
   end

   // Molecule bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (cmd.clear_mol) begin
            total_ff <= '0;
            ready_ff <= 1'b0;
         end else if (cmd.store_bond) begin
            total_ff <= total_ff + CW'(1);
         end
         if (cmd.set_ready) begin
            ready_ff <= 1'b1;
         end
      end
   end

   // Build loop counters.
   always_ff @(posedge clock) begin
      if (cmd.build_init) begin
         i_ff <= '0;
      end else if (cmd.i_inc) begin
         i_ff <= i_ff + CW'(1);
      end
      if (cmd.j_init) begin
         j_ff <= i_ff + CW'(1);
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + CW'(1);
      end
      if (cmd.k_clr) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + 2'd1;
      end
   end

   // Bond list memory.
   assign bond_raddr = cmd.rd_bond_i ? i_ff[BIW-1:0] : j_ff[BIW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.store_bond) begin
         bond_mem_ff[total_ff[BIW-1:0]] <= {a_ff, b_ff};
      end
      bond_q_ff <= bond_mem_ff[bond_raddr];
   end

   // Bond registers of the current pair of bonds.
   always_ff @(posedge clock) begin
      if (cmd.cap_i) begin
         ai_ff <= bond_q_ff[2*ATOM_W-1:ATOM_W];
         bi_ff <= bond_q_ff[ATOM_W-1:0];
      end
      if (cmd.cap_j) begin
         aj_ff <= bond_q_ff[2*ATOM_W-1:ATOM_W];
         bj_ff <= bond_q_ff[ATOM_W-1:0];
      end
      if (cmd.cap_rowa) begin
         row_a_ff <= adj_row;
      end
      if (cmd.cap_rowb) begin
         row_b_ff <= adj_row;
      end
   end

   // Adjacency port: one read and one write address per cycle.
   always_comb begin
      priority if (cmd.cap_i) begin
         adj_raddr = bond_q_ff[2*ATOM_W-1:ATOM_W];
      end else if (cmd.cap_rowa) begin
         adj_raddr = bi_ff;
      end else if (cmd.adj_wr_a) begin
         adj_raddr = b_ff;
      end else begin
         adj_raddr = a_ff;
      end
   end

   assign adj_row   = adj_rv_ff ? adj_q_ff : '0;
   assign adj_we    = cmd.adj_wr_a | cmd.adj_wr_b;
   assign adj_waddr = cmd.adj_wr_a ? a_ff : b_ff;
   assign adj_wdata = adj_row | (MAX_ATOMS'(1) << (cmd.adj_wr_a ? b_ff : a_ff));

   always_ff @(posedge clock) begin
      if (adj_we) begin
         adj_mem_ff[adj_waddr] <= adj_wdata;
      end
      adj_q_ff  <= adj_mem_ff[adj_raddr];
      adj_rv_ff <= adj_valid_ff[adj_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_mol) begin
         adj_valid_ff <= '0;
      end else if (adj_we) begin
         adj_valid_ff[adj_waddr] <= 1'b1;
      end
   end

   // Shared-atom case and cross-check selection.
   always_comb begin
      priority if (ai_ff == aj_ff) begin
         share_k = 2'd0;
      end else if (ai_ff == bj_ff) begin
         share_k = 2'd1;
      end else if (bi_ff == aj_ff) begin
         share_k = 2'd2;
      end else begin
         share_k = 2'd3;
      end
   end

   assign pair_sel = (cmd.tgt == TGT_SHARE) ? share_k : k_ff;

   // Target pair of the cell port.
   always_comb begin
      tgt_x = a_ff;
      tgt_y = b_ff;
      unique case (cmd.tgt)
         TGT_IN: begin
            tgt_x = a_ff;
            tgt_y = b_ff;
         end
         TGT_BOND: begin
            tgt_x = ai_ff;
            tgt_y = bi_ff;
         end
         TGT_SHARE, TGT_CROSS: begin
            unique case (pair_sel)
               2'd0: begin
                  tgt_x = bi_ff;
                  tgt_y = bj_ff;
               end
               2'd1: begin
                  tgt_x = bi_ff;
                  tgt_y = aj_ff;
               end
               2'd2: begin
                  tgt_x = ai_ff;
                  tgt_y = bj_ff;
               end
               default: begin
                  tgt_x = ai_ff;
                  tgt_y = aj_ff;
               end
            endcase
         end
         default: begin
            tgt_x = a_ff;
            tgt_y = b_ff;
         end
      endcase
   end

   assign tgt_row = (tgt_x < tgt_y) ? tgt_x : tgt_y;
   assign tgt_col = (tgt_x < tgt_y) ? tgt_y : tgt_x;

   // Relation cell memory, read-modify-write of one row.
   assign cell_base  = cell_rv_ff ? cell_q_ff : {MAX_ATOMS{REL_NONE}};
   assign cell_shift = {ccol_ff, 1'b0};
   assign cell_val   = 2'(cell_base >> cell_shift);
   assign cell_wdata = (cell_base & ~(ROW_W'(3) << cell_shift))
                     | (ROW_W'(cmd.cell_val) << cell_shift);

   always_ff @(posedge clock) begin
      if (cmd.cell_wr) begin
         cell_mem_ff[crow_ff] <= cell_wdata;
      end
      cell_q_ff  <= cell_mem_ff[tgt_row];
      cell_rv_ff <= cell_valid_ff[tgt_row];
      if (cmd.cell_rd) begin
         crow_ff <= tgt_row;
         ccol_ff <= tgt_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.build_init) begin
         cell_valid_ff <= '0;
      end else if (cmd.cell_wr) begin
         cell_valid_ff[crow_ff] <= 1'b1;
      end
   end

   // Result being formed.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rel_ff  <= REL_BONDED;
         stat_ff <= STAT_OK;
      end else begin
         if (cmd.stat_load) begin
            stat_ff <= cmd.stat_val;
         end
         if (cmd.rel_load) begin
            rel_ff <= cell_val;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_relation_ff <= rel_ff;
         rsp_status_ff   <= stat_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_relation = rsp_relation_ff;
   assign rsp_status   = rsp_status_ff;

   // Status toward the controller.
   assign n_valid = (atom_count_ff > CNT_W'(MAX_ATOMS)) ? CNT_W'(MAX_ATOMS) : atom_count_ff;

   always_comb begin
      st.func      = func_ff;
      st.last      = last_ff;
      st.bad_index = ({1'b0, a_ff} >= n_valid) || ({1'b0, b_ff} >= n_valid);
      st.list_full = total_ff >= CW'(MAX_BONDS);
      st.ready     = ready_ff;
      st.i_done    = i_ff >= total_ff;
      st.j_done    = j_ff >= total_ff;
      st.shared    = (ai_ff == aj_ff) || (ai_ff == bj_ff)
                  || (bi_ff == aj_ff) || (bi_ff == bj_ff);
      unique case (k_ff)
         2'd0:    st.linked = row_a_ff[aj_ff];
         2'd1:    st.linked = row_a_ff[bj_ff];
         2'd2:    st.linked = row_b_ff[aj_ff];
         default: st.linked = row_b_ff[bj_ff];
      endcase
      st.cell_is3  = cell_val == REL_NONE;
      st.k_last    = k_ff == 2'd3;
      st.out_busy  = rsp_valid_ff && rsp_stall;
   end

endmodule

@@ src/bgrm_ctrl.sv @@
module bgrm_ctrl import bgrm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  bgrm_stat_type st,
   output bgrm_cmd_type  cmd
);

   bgrm_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (st.func) begin
               if (!st.ready) begin
                  cmd.stat_load = 1'b1;
                  cmd.stat_val  = STAT_NOT_BUILT;
                  state_in      = ST_RESULT;
               end else if (st.bad_index) begin
                  cmd.stat_load = 1'b1;
                  cmd.stat_val  = STAT_BAD_INDEX;
                  state_in      = ST_RESULT;
               end else begin
                  cmd.cell_rd = 1'b1;
                  cmd.tgt     = TGT_IN;
                  state_in    = ST_QRD;
               end
            end else begin
               cmd.clear_mol = st.ready;
               state_in      = ST_LD_CHK;
            end
         end
         ST_LD_CHK: begin
            if (st.bad_index) begin
               cmd.stat_load = 1'b1;
               cmd.stat_val  = STAT_BAD_INDEX;
               state_in      = ST_LD_LAST;
            end else if (st.list_full) begin
               cmd.stat_load = 1'b1;
               cmd.stat_val  = STAT_LIST_FULL;
               state_in      = ST_LD_LAST;
            end else begin
               cmd.store_bond = 1'b1;
               state_in       = ST_LD_ADJA;
            end
         end
         ST_LD_ADJA: begin
            cmd.adj_wr_a = 1'b1;
            state_in     = ST_LD_ADJB;
         end
         ST_LD_ADJB: begin
            cmd.adj_wr_b = 1'b1;
            state_in     = ST_LD_LAST;
         end
         ST_LD_LAST: begin
            state_in = st.last ? ST_BLD_INIT : ST_RESULT;
         end
         ST_BLD_INIT: begin
            cmd.build_init = 1'b1;
            state_in       = ST_BLD_I;
         end
         ST_BLD_I: begin
            if (st.i_done) begin
               cmd.set_ready = 1'b1;
               state_in      = ST_RESULT;
            end else begin
               cmd.rd_bond_i = 1'b1;
               state_in      = ST_BLD_IRD;
            end
         end
         ST_BLD_IRD: begin
            cmd.cap_i = 1'b1;
            state_in  = ST_BLD_ROWA;
         end
         ST_BLD_ROWA: begin
            cmd.cap_rowa = 1'b1;
            state_in     = ST_BLD_ROWB;
         end
         ST_BLD_ROWB: begin
            cmd.cap_rowb = 1'b1;
            cmd.cell_rd  = 1'b1;
            cmd.tgt      = TGT_BOND;
            state_in     = ST_BLD_BWR;
         end
         ST_BLD_BWR: begin
            cmd.cell_wr  = 1'b1;
            cmd.cell_val = REL_BONDED;
            cmd.j_init   = 1'b1;
            state_in     = ST_BLD_J;
         end
         ST_BLD_J: begin
            if (st.j_done) begin
               cmd.i_inc = 1'b1;
               state_in  = ST_BLD_I;
            end else begin
               state_in = ST_BLD_JRD;
            end
         end
         ST_BLD_JRD: begin
            cmd.cap_j = 1'b1;
            cmd.k_clr = 1'b1;
            state_in  = ST_BLD_SEL;
         end
         ST_BLD_SEL: begin
            if (st.shared) begin
               cmd.cell_rd = 1'b1;
               cmd.tgt     = TGT_SHARE;
               state_in    = ST_BLD_SHWR;
            end else begin
               state_in = ST_BLD_X;
            end
         end
         ST_BLD_SHWR: begin
            cmd.cell_wr  = 1'b1;
            cmd.cell_val = REL_ONE_THREE;
            cmd.j_inc    = 1'b1;
            state_in     = ST_BLD_J;
         end
         ST_BLD_X: begin
            if (st.linked) begin
               cmd.cell_rd = 1'b1;
               cmd.tgt     = TGT_CROSS;
               state_in    = ST_BLD_XRD;
            end else if (st.k_last) begin
               cmd.j_inc = 1'b1;
               state_in  = ST_BLD_J;
            end else begin
               cmd.k_inc = 1'b1;
            end
         end
         ST_BLD_XRD: begin
            if (st.cell_is3) begin
               cmd.cell_wr  = 1'b1;
               cmd.cell_val = REL_ONE_FOUR;
               cmd.j_inc    = 1'b1;
               state_in     = ST_BLD_J;
            end else if (st.k_last) begin
               cmd.j_inc = 1'b1;
               state_in  = ST_BLD_J;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_BLD_X;
            end
         end
         ST_QRD: begin
            cmd.rel_load = 1'b1;
            state_in     = ST_RESULT;
         end
         ST_RESULT: begin
            if (!st.out_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/bond_graph_relation_matrix_unit.sv @@
// Bond graph relation matrix unit.
// Requests arrive on req_valid/req_stall with func, atom_a, atom_b and
// last_bond. A load (func 0) stores one bond; a load with last_bond set
// then builds the triangular relation matrix. A query (func 1) returns the
// relation of an atom pair. Every request yields exactly one response on
// rsp_valid/rsp_stall with relation and status.
// One request is worked on at a time; req_stall is high from acceptance
// until the response is placed in the output register. A build goes
// through every stored bond and every bond pair, using read-modify-write
// of the relation cell memory.
// The output register lets the next request be accepted while a response
// still waits; if the receiver stalls, the unit holds its finished result
// and stops accepting until the output register frees up.
// Synchronous reset empties the bond list, clears adjacency and relation
// rows through row valid bits, marks the matrix as not built and sets
// atom_count to 64. No clearing pass is needed. Users write atom_count
// via csr_wr_en/csr_wr_data only while idle; not enforced by the unit.
module bond_graph_relation_matrix_unit import bgrm_pkg::*; #(
   parameter int MAX_BONDS = MAX_BONDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CNT_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [ATOM_W-1:0] req_atom_a,
   input  logic [ATOM_W-1:0] req_atom_b,
   input  logic              req_last_bond,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_relation,
   output logic [1:0]        rsp_status
);

   bgrm_cmd_type  cmd;
   bgrm_stat_type st;

   // Sequencer.
   bgrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // Storage and arithmetic.
   bgrm_datapath #(
      .MAX_BONDS (MAX_BONDS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_func      (req_func),
      .req_atom_a    (req_atom_a),
      .req_atom_b    (req_atom_b),
      .req_last_bond (req_last_bond),
      .cmd           (cmd),
      .st            (st),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_relation  (rsp_relation),
      .rsp_status    (rsp_status)
   );

endmodule

@@ src/bgrm_checker.sv @@
`include "bond_graph_relation_matrix_unit_defines.svh"

module bgrm_checker import bgrm_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              csr_wr_en,
   input logic [CNT_W-1:0]  csr_wr_data,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_func,
   input logic [ATOM_W-1:0] req_atom_a,
   input logic [ATOM_W-1:0] req_atom_b,
   input logic              req_last_bond,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_relation,
   input logic [1:0]        rsp_status
);

   // A stalled response stays valid and unchanged.
   `BGRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_relation) && $stable(rsp_status), "stalled response changed")

   // Only one request is in work: the unit stalls right after accepting one.
   `BGRM_ASSERT_NEXT(a_single_request, req_valid && !req_stall, req_stall, "request accepted while busy")

   // A failed request leaves the relation field at REL_BONDED.
   `BGRM_ASSERT_SAME(a_rel_on_error, rsp_valid && rsp_status != STAT_OK, rsp_relation == REL_BONDED, "relation set on failed request")

endmodule

bind bond_graph_relation_matrix_unit bgrm_checker u_bgrm_checker (.*);
